/* hdl/jet_pkg.sv */
// Package for the Julia escape-time pixel unit: widths, register indexes and
// the constant intensity table. No dependencies.
package jet_pkg;

   localparam int MAX_ITER  = 40;
   localparam int FRAC_BITS = 12;

   // Field widths
   localparam int COORD_W = 16;
   localparam int CSR_W   = 32;
   localparam int STEP_W  = 6;
   localparam int INT_W   = 8;
   localparam int INDEX_W = 2;

   // Running z fits in Z_W bits: an update happens only while |z|^2 <= bailout,
   // so each new part stays below 2^20 + 2^15 in magnitude.
   localparam int Z_W    = 22;
   localparam int PROD_W = 2 * Z_W;
   localparam int MAG_W  = PROD_W + 1;

   // Configuration register indexes
   localparam logic [INDEX_W-1:0] REG_C_REAL     = 2'd0;
   localparam logic [INDEX_W-1:0] REG_C_IMAG     = 2'd1;
   localparam logic [INDEX_W-1:0] REG_BAILOUT_SQ = 2'd2;

   // Register reset values
   localparam logic signed [COORD_W-1:0] C_REAL_RESET     = -16'sd2048;
   localparam logic signed [COORD_W-1:0] C_IMAG_RESET     = 16'sd2621;
   localparam logic [CSR_W-1:0]          BAILOUT_SQ_RESET = 32'd167772160;

   localparam logic [STEP_W-1:0] LAST_ITER = STEP_W'(MAX_ITER - 1);
   localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(MAX_ITER);

   typedef logic [INT_W*(MAX_ITER+1)-1:0] intensity_lut_type;

   // round(255*sqrt(s/MAX_ITER)), ties up: the largest n with
   // MAX_ITER*(2n-1)^2 <= 4*65025*s. Evaluated at elaboration only.
   function automatic intensity_lut_type build_intensity_lut();
      intensity_lut_type lut;
      longint unsigned   lhs;
      longint unsigned   odd;
      logic [INT_W-1:0]  n;
      lut = '0;
      for (int s = 0; s <= MAX_ITER; s++) begin
         lhs = 64'(260100) * 64'(s);
         n   = '0;
         for (int k = 1; k <= 255; k++) begin
            odd = 64'(2 * k - 1);
            if (64'(MAX_ITER) * odd * odd <= lhs) begin
               n = INT_W'(k);
            end
         end
         lut[s*INT_W +: INT_W] = n;
      end
      return lut;
   endfunction

   localparam intensity_lut_type INTENSITY_LUT = build_intensity_lut();

endpackage

/* hdl/julia_escape_time_pixel_unit.sv */
// Julia set escape-time pixel unit: iterates z = z*z + c on one start point.
// Depends on jet_pkg (widths, register indexes, intensity table).

// One start point is taken per transfer on req_*, and one result leaves per
// transfer on rsp_*. The point is iterated on a single complex-squaring unit
// (three 22x22 multipliers feeding one add/compare/shift stage): in each
// iteration ST_MUL forms re*re, im*im and re*im, and ST_UPD tests
// |z|^2 > bailout_sq and writes back the new z. A new point is taken only in
// ST_IDLE, once the last one has finished and its result has left for the
// output register. The result sits in an output register, so the next point
// is taken while an earlier result still waits for rsp_ready. The constant c
// and the threshold are written through csr_*; the user must write them only
// while the unit is idle, which the unit itself does not enforce. Writes to an
// unknown index are dropped. The intensity is read from a constant table.
module julia_escape_time_pixel_unit (
   input  logic                                clock,
   input  logic                                reset,
   // start point channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [jet_pkg::COORD_W-1:0]  req_start_real,
   input  logic signed [jet_pkg::COORD_W-1:0]  req_start_imag,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [jet_pkg::STEP_W-1:0]   rsp_escape_step,
   output logic                                rsp_escaped,
   output logic        [jet_pkg::INT_W-1:0]    rsp_intensity,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic        [jet_pkg::INDEX_W-1:0]  csr_index,
   input  logic        [jet_pkg::CSR_W-1:0]    csr_wdata
);

   // Sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a start point
   localparam logic [1:0] ST_MUL  = 2'd1;  // form the three products
   localparam logic [1:0] ST_UPD  = 2'd2;  // test bailout, write back z
   localparam logic [1:0] ST_HOLD = 2'd3;  // result done, output register full

   // Configuration registers
   logic signed [jet_pkg::COORD_W-1:0] c_real_ff;
   logic signed [jet_pkg::COORD_W-1:0] c_imag_ff;
   logic        [jet_pkg::CSR_W-1:0]   bailout_ff;

   // Sequencer and iteration state
   logic [1:0]                         state_ff, state_in;
   logic [jet_pkg::STEP_W-1:0]         iter_ff, iter_in;
   logic signed [jet_pkg::Z_W-1:0]     re_ff, re_in;
   logic signed [jet_pkg::Z_W-1:0]     im_ff, im_in;
   logic signed [jet_pkg::PROD_W-1:0]  rr_ff, ii_ff, ri_ff;

   // Finished result waiting for the output register
   logic [jet_pkg::STEP_W-1:0]         done_step_ff, done_step_in;
   logic                               done_esc_ff, done_esc_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [jet_pkg::STEP_W-1:0]         rsp_step_ff, rsp_step_in;
   logic                               rsp_esc_ff, rsp_esc_in;
   logic [jet_pkg::INT_W-1:0]          rsp_int_ff, rsp_int_in;

   // Datapath
   logic [jet_pkg::MAG_W-1:0]          mag;
   logic                               escape_now;
   logic signed [jet_pkg::MAG_W-1:0]   diff;
   logic signed [jet_pkg::MAG_W-1:0]   diff_shr;
   logic signed [jet_pkg::PROD_W-1:0]  cross_shr;
   logic                               out_free;
   logic                               finish;
   logic [jet_pkg::STEP_W-1:0]         fin_step;
   logic                               fin_esc;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // |z|^2 and the next z from the registered products
   assign mag        = jet_pkg::MAG_W'($unsigned(rr_ff)) + jet_pkg::MAG_W'($unsigned(ii_ff));
   assign escape_now = mag > jet_pkg::MAG_W'(bailout_ff);
   assign diff       = jet_pkg::MAG_W'(rr_ff) - jet_pkg::MAG_W'(ii_ff);
   // floor shift; 2*re*im shifted by FRAC_BITS is re*im shifted by one less
   assign diff_shr   = diff >>> jet_pkg::FRAC_BITS;
   assign cross_shr  = ri_ff >>> (jet_pkg::FRAC_BITS - 1);

   // Finish on escape, or after the test of the last step fails
   assign finish   = (state_ff == ST_UPD) && (escape_now || (iter_ff == jet_pkg::LAST_ITER));
   assign fin_step = escape_now ? iter_ff : jet_pkg::STEP_MAX;
   assign fin_esc  = escape_now;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      done_step_in = done_step_ff;
      done_esc_in  = done_esc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_int_in   = rsp_int_ff;

      // drop the result once it is transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               re_in    = jet_pkg::Z_W'(req_start_real);
               im_in    = jet_pkg::Z_W'(req_start_imag);
               iter_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_step_in  = fin_step;
                  rsp_esc_in   = fin_esc;
                  rsp_int_in   = fin_esc ?
                     jet_pkg::INTENSITY_LUT[fin_step*jet_pkg::INT_W +: jet_pkg::INT_W] : '0;
                  state_in     = ST_IDLE;
               end else begin
                  done_step_in = fin_step;
                  done_esc_in  = fin_esc;
                  state_in     = ST_HOLD;
               end
            end else begin
               re_in    = jet_pkg::Z_W'(diff_shr) + jet_pkg::Z_W'(c_real_ff);
               im_in    = jet_pkg::Z_W'(cross_shr) + jet_pkg::Z_W'(c_imag_ff);
               iter_in  = iter_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_step_in  = done_step_ff;
               rsp_esc_in   = done_esc_ff;
               rsp_int_in   = done_esc_ff ?
                  jet_pkg::INTENSITY_LUT[done_step_ff*jet_pkg::INT_W +: jet_pkg::INT_W] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff  <= jet_pkg::C_REAL_RESET;
         c_imag_ff  <= jet_pkg::C_IMAG_RESET;
         bailout_ff <= jet_pkg::BAILOUT_SQ_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            jet_pkg::REG_C_REAL:     c_real_ff  <= jet_pkg::COORD_W'(csr_wdata);
            jet_pkg::REG_C_IMAG:     c_imag_ff  <= jet_pkg::COORD_W'(csr_wdata);
            jet_pkg::REG_BAILOUT_SQ: bailout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Payload registers; the multipliers load every cycle from the current z
   always_ff @(posedge clock) begin
      re_ff        <= re_in;
      im_ff        <= im_in;
      rr_ff        <= re_ff * re_ff;
      ii_ff        <= im_ff * im_ff;
      ri_ff        <= re_ff * im_ff;
      done_step_ff <= done_step_in;
      done_esc_ff  <= done_esc_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_esc_ff   <= rsp_esc_in;
      rsp_int_ff   <= rsp_int_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_escape_step = rsp_step_ff;
   assign rsp_escaped     = rsp_esc_ff;
   assign rsp_intensity   = rsp_int_ff;

   // A transferred start point always starts a product cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL))
      else $error("accepted point did not start iterating");

   // The step counter never passes the last step while iterating
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_UPD) |-> (iter_ff <= jet_pkg::LAST_ITER))
      else $error("iteration count out of range");

   // A held result means the output register is still occupied
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result held while output register is empty");

   // A point that never escaped reports the full count and zero intensity
   a_no_escape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_esc_ff) |->
         (rsp_step_ff == jet_pkg::STEP_MAX && rsp_int_ff == '0))
      else $error("non-escaped result has wrong step or intensity");

endmodule
